>>> hdl/bir_pkg.sv
// Shared types and constants of the bilinear image resize core.
package bir_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_INTERP     = 3'd4;

  // Request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Size limits and internal widths
  localparam int unsigned DST_LIMIT = 4096;
  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned COORD_W   = 12;

  // Controller state, one-hot
  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_MULA  = 13'b0000000000010,
    ST_LDX   = 13'b0000000000100,
    ST_DIVX  = 13'b0000000001000,
    ST_LDY   = 13'b0000000010000,
    ST_DIVY  = 13'b0000000100000,
    ST_COORD = 13'b0000001000000,
    ST_READ  = 13'b0000010000000,
    ST_RWAIT = 13'b0000100000000,
    ST_HMUL  = 13'b0001000000000,
    ST_VMUL1 = 13'b0010000000000,
    ST_VMUL2 = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_write;
    logic       query_latch;
    logic       mul_a;
    logic       div_load;
    logic       div_step;
    logic       div_sel_y;
    logic       coord;
    logic       rd_en;
    logic [1:0] rd_idx;
    logic       hmul;
    logic       vmul1;
    logic       vmul2;
    logic       out_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic nearest;
  } status_t;

endpackage

>>> hdl/bir_if.sv
// Channel interfaces: input requests, output pixels, configuration writes.
interface bir_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [11:0] col;
  logic [11:0] row;
  logic [1:0]  channel;
  logic [7:0]  pixel_in;
  modport source (output valid, req_type, col, row, channel, pixel_in, input ready);
  modport sink   (input valid, req_type, col, row, channel, pixel_in, output ready);
endinterface

interface bir_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

interface bir_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bilinear_image_resize_core.sv
// Top level of the bilinear image resize core.
// Load transactions write one 8-bit pixel into an on-chip frame store of
// MAX_WIDTH*MAX_HEIGHT*MAX_CHANNELS entries and give no result. A query
// transaction maps the output pixel center back to the source with FRAC_BITS
// fractional bits and returns one pixel. Each query runs two restoring
// divisions of 26+FRAC_BITS quotient bits each (one quotient bit per cycle,
// column then row), then reads its neighbors from the single-port frame store
// one per cycle: four for a bilinear query, one for a nearest query. A new
// transaction is taken while the previous result still waits at the output.
// Frame store entries that were never loaded read as unknown values.
module bilinear_image_resize_core #(
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bir_in_if.sink     in_i,
  bir_out_if.source  out_o,
  bir_cfg_if.sink    cfg_i
);
  bir_pkg::cmd_t    cmd;
  bir_pkg::status_t status;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  bir_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_req_type_i (in_i.req_type),
    .in_ready_o    (in_i.ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  bir_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .in_col_i     (in_i.col),
    .in_row_i     (in_i.row),
    .in_channel_i (in_i.channel),
    .in_pixel_i   (in_i.pixel_in),
    .pixel_out_o  (out_o.pixel_out),
    .cmd_i        (cmd),
    .status_o     (status)
  );
endmodule

>>> hdl/bir_ram.sv
// Generic single-port RAM with registered read.
module bir_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end
endmodule

>>> hdl/bir_ctrl.sv
// Controller: sequences loads, coordinate mapping, neighbor reads and blending.
module bir_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output bir_pkg::cmd_t     cmd_o,
  input  bir_pkg::status_t  status_i
);
  bir_pkg::state_e state_q, state_d;
  logic [1:0] rd_cnt_q, rd_cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;
  logic       rd_last;

  assign in_ready_o  = (state_q == bir_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign rd_last     = status_i.nearest || (rd_cnt_q == 2'd3);

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      bir_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type_i == bir_pkg::REQ_LOAD) begin
            cmd_o.load_write = 1'b1;
          end else begin
            cmd_o.query_latch = 1'b1;
            state_d = bir_pkg::ST_MULA;
          end
        end
      end
      bir_pkg::ST_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d = bir_pkg::ST_LDX;
      end
      bir_pkg::ST_LDX: begin
        cmd_o.div_load = 1'b1;
        state_d = bir_pkg::ST_DIVX;
      end
      bir_pkg::ST_DIVX: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = bir_pkg::ST_LDY;
      end
      bir_pkg::ST_LDY: begin
        cmd_o.div_load  = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        state_d = bir_pkg::ST_DIVY;
      end
      bir_pkg::ST_DIVY: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_sel_y = 1'b1;
        if (status_i.div_last) state_d = bir_pkg::ST_COORD;
      end
      bir_pkg::ST_COORD: begin
        cmd_o.coord = 1'b1;
        rd_cnt_d = 2'd0;
        state_d = bir_pkg::ST_READ;
      end
      bir_pkg::ST_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_idx = rd_cnt_q;
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_last) state_d = bir_pkg::ST_RWAIT;
      end
      bir_pkg::ST_RWAIT: begin
        state_d = status_i.nearest ? bir_pkg::ST_DONE : bir_pkg::ST_HMUL;
      end
      bir_pkg::ST_HMUL: begin
        cmd_o.hmul = 1'b1;
        state_d = bir_pkg::ST_VMUL1;
      end
      bir_pkg::ST_VMUL1: begin
        cmd_o.vmul1 = 1'b1;
        state_d = bir_pkg::ST_VMUL2;
      end
      bir_pkg::ST_VMUL2: begin
        cmd_o.vmul2 = 1'b1;
        state_d = bir_pkg::ST_DONE;
      end
      bir_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = bir_pkg::ST_IDLE;
        end
      end
      default: state_d = bir_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bir_pkg::ST_IDLE;
      rd_cnt_q    <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

>>> hdl/bir_datapath.sv
// Datapath: configuration, coordinate divider, frame store access and blending.
module bir_datapath #(
  parameter int unsigned MAX_WIDTH    = 256,
  parameter int unsigned MAX_HEIGHT   = 256,
  parameter int unsigned MAX_CHANNELS = 4,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [12:0]       cfg_data_i,
  input  logic [11:0]       in_col_i,
  input  logic [11:0]       in_row_i,
  input  logic [1:0]        in_channel_i,
  input  logic [7:0]        in_pixel_i,
  output logic [7:0]        pixel_out_o,
  input  bir_pkg::cmd_t     cmd_i,
  output bir_pkg::status_t  status_o
);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int unsigned ADW   = $clog2(DEPTH);
  localparam int unsigned SW    = bir_pkg::SIZE_W;
  localparam int unsigned CW    = bir_pkg::COORD_W;
  localparam int unsigned AW    = 2 * SW;
  localparam int unsigned NW    = AW + FRAC_BITS;
  localparam int unsigned IW    = NW - FRAC_BITS + 1;
  localparam int unsigned CNTW  = $clog2(NW);
  localparam int unsigned HW    = FRAC_BITS + 8;
  localparam int unsigned ACCW  = 2 * FRAC_BITS + 9;
  localparam logic [NW:0]       HALF   = (NW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [ACCW-1:0]   RND    = ACCW'(1) << (2 * FRAC_BITS - 1);

  // Clamp a signed index into 0 .. size-1
  function automatic logic [CW-1:0] clamp_idx(input logic signed [IW-1:0] v,
                                              input logic [SW-1:0] sz);
    logic [SW-1:0] lim;
    lim = sz - SW'(1);
    if (v < 0) return '0;
    if (v > $signed({{(IW-SW){1'b0}}, lim})) return lim[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Frame store address of (x, y, c)
  function automatic logic [ADW-1:0] px_addr(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                            input logic [1:0] c);
    logic [31:0] a;
    a = ({20'd0, y} * MAX_WIDTH + {20'd0, x}) * MAX_CHANNELS + {30'd0, c};
    return a[ADW-1:0];
  endfunction

  // Configuration registers
  logic [8:0]  src_w_q, src_h_q;
  logic [12:0] dst_w_q, dst_h_q;
  logic        mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd256;
      src_h_q <= 9'd256;
      dst_w_q <= 13'd256;
      dst_h_q <= 13'd256;
      mode_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bir_pkg::CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[8:0];
        bir_pkg::CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[8:0];
        bir_pkg::CFG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        bir_pkg::CFG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        bir_pkg::CFG_INTERP:     mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturated sizes
  logic [SW-1:0] sw_sat, sh_sat, dw_sat, dh_sat;
  always_comb begin
    sw_sat = (src_w_q == 9'd0) ? SW'(1) :
             ({4'd0, src_w_q} > SW'(MAX_WIDTH)) ? SW'(MAX_WIDTH) : {4'd0, src_w_q};
    sh_sat = (src_h_q == 9'd0) ? SW'(1) :
             ({4'd0, src_h_q} > SW'(MAX_HEIGHT)) ? SW'(MAX_HEIGHT) : {4'd0, src_h_q};
    dw_sat = (dst_w_q == 13'd0) ? SW'(1) :
             (dst_w_q > SW'(bir_pkg::DST_LIMIT)) ? SW'(bir_pkg::DST_LIMIT) : dst_w_q;
    dh_sat = (dst_h_q == 13'd0) ? SW'(1) :
             (dst_h_q > SW'(bir_pkg::DST_LIMIT)) ? SW'(bir_pkg::DST_LIMIT) : dst_h_q;
  end

  assign status_o.nearest = mode_q;

  // Query latch and numerators (2*out+1)*src_size
  logic [CW-1:0] qcol_q, qrow_q;
  logic [1:0]    qch_q;
  logic [AW-1:0] ax_q, ay_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_latch) begin
      qcol_q <= in_col_i;
      qrow_q <= in_row_i;
      qch_q  <= ({1'b0, in_channel_i} >= 3'(MAX_CHANNELS)) ? 2'(MAX_CHANNELS - 1)
                                                           : in_channel_i;
    end
    if (cmd_i.mul_a) begin
      ax_q <= {qcol_q, 1'b1} * sw_sat;
      ay_q <= {qrow_q, 1'b1} * sh_sat;
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [NW-1:0]   num_q, quo_q, tx_q, ty_q;
  logic [SW:0]     rem_q, den_q, trial;
  logic            qbit;
  logic [NW-1:0]   quo_next;
  logic [CNTW-1:0] cnt_q;

  assign trial    = {rem_q[SW-1:0], num_q[NW-1]};
  assign qbit     = (trial >= den_q);
  assign quo_next = {quo_q[NW-2:0], qbit};
  assign status_o.div_last = (cnt_q == CNTW'(NW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      num_q <= {(cmd_i.div_sel_y ? ay_q : ax_q), {FRAC_BITS{1'b0}}};
      den_q <= {(cmd_i.div_sel_y ? dh_sat : dw_sat), 1'b0};
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= qbit ? (trial - den_q) : trial;
      quo_q <= quo_next;
      if (status_o.div_last) begin
        if (cmd_i.div_sel_y) ty_q <= quo_next;
        else                 tx_q <= quo_next;
      end
    end
  end

  // Neighbor coordinates and fractions
  logic [NW:0]            sx, sy;
  logic signed [IW-1:0]   ix, iy, nx, ny;
  logic [CW-1:0]          x0_q, x1_q, y0_q, y1_q;
  logic [FRAC_BITS-1:0]   fx_q, fy_q;

  assign sx = {1'b0, tx_q} - HALF;
  assign sy = {1'b0, ty_q} - HALF;
  assign ix = sx[NW:FRAC_BITS];
  assign iy = sy[NW:FRAC_BITS];
  assign nx = {1'b0, tx_q[NW-1:FRAC_BITS]};
  assign ny = {1'b0, ty_q[NW-1:FRAC_BITS]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.coord) begin
      x0_q <= clamp_idx(mode_q ? nx : ix, sw_sat);
      y0_q <= clamp_idx(mode_q ? ny : iy, sh_sat);
      x1_q <= clamp_idx(ix + IW'(1), sw_sat);
      y1_q <= clamp_idx(iy + IW'(1), sh_sat);
      fx_q <= sx[FRAC_BITS-1:0];
      fy_q <= sy[FRAC_BITS-1:0];
    end
  end

  // Frame store port: load writes or neighbor reads
  logic           ld_ok, ram_en;
  logic [ADW-1:0] ram_addr, rd_addr;
  logic [7:0]     ram_rdata;

  assign ld_ok = ({1'b0, in_col_i} < 13'(MAX_WIDTH)) && ({1'b0, in_row_i} < 13'(MAX_HEIGHT))
              && ({1'b0, in_channel_i} < 3'(MAX_CHANNELS));

  always_comb begin
    case (cmd_i.rd_idx)
      2'd0:    rd_addr = px_addr(x0_q, y0_q, qch_q);
      2'd1:    rd_addr = px_addr(x1_q, y0_q, qch_q);
      2'd2:    rd_addr = px_addr(x0_q, y1_q, qch_q);
      default: rd_addr = px_addr(x1_q, y1_q, qch_q);
    endcase
    ram_addr = cmd_i.load_write ? px_addr(in_col_i, in_row_i, in_channel_i) : rd_addr;
    ram_en   = (cmd_i.load_write && ld_ok) || cmd_i.rd_en;
  end

  bir_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (cmd_i.load_write),
    .addr_i  (ram_addr),
    .wdata_i (in_pixel_i),
    .rdata_o (ram_rdata)
  );

  // Capture read data in the cycle after its address
  logic       rd_vld_q;
  logic [1:0] rd_idx_q;
  logic [7:0] pix_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= 2'd0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      rd_idx_q <= cmd_i.rd_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) pix_q[rd_idx_q] <= ram_rdata;
  end

  // Blend: horizontal pairs, then vertical, then round
  logic [FRAC_BITS:0]  gx, gy;
  logic [HW:0]         h0, h1;
  logic [HW-1:0]       h0_q, h1_q;
  logic [ACCW-1:0]     m_q, acc_q;
  logic [8:0]          res_full;
  logic [7:0]          out_q;

  assign gx = ONE - {1'b0, fx_q};
  assign gy = ONE - {1'b0, fy_q};
  assign h0 = (HW+1)'(pix_q[0] * gx) + (HW+1)'(pix_q[1] * fx_q);
  assign h1 = (HW+1)'(pix_q[2] * gx) + (HW+1)'(pix_q[3] * fx_q);
  assign res_full = acc_q[ACCW-1:2*FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.hmul) begin
      h0_q <= h0[HW-1:0];
      h1_q <= h1[HW-1:0];
    end
    if (cmd_i.vmul1) m_q <= ACCW'(h0_q * gy);
    if (cmd_i.vmul2) acc_q <= m_q + ACCW'(h1_q * fy_q) + RND;
    if (cmd_i.out_load) begin
      if (mode_q)              out_q <= pix_q[0];
      else if (res_full[8])    out_q <= 8'hFF;
      else                     out_q <= res_full[7:0];
    end
  end

  assign pixel_out_o = out_q;
endmodule

>>> tb/sv/bir_resize_checker.sv
`timescale 1ns / 1ps
// Transaction monitor and pixel predictor for the bilinear image resize core.
module bir_resize_checker
  import bir_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  bir_in_if    in_mon,
  bir_out_if   out_mon,
  bir_cfg_if   cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned FRAC = 16;
  localparam int unsigned IMG_W = 256;
  localparam int unsigned IMG_H = 256;
  localparam int unsigned CHANS = 4;
  localparam longint HALF = 64'sd1 << (FRAC - 1);
  localparam longint ONE = 64'sd1 << FRAC;

  // Shadow copy of the frame store and the size/mode registers
  logic [7:0]  pix_mem [0:IMG_W*IMG_H*CHANS-1];
  logic [8:0]  src_w_q;
  logic [8:0]  src_h_q;
  logic [12:0] dst_w_q;
  logic [12:0] dst_h_q;
  logic        nearest_q;
  logic [7:0]  expected_pixels [$];

  initial begin
    foreach (pix_mem[i]) pix_mem[i] = 8'd0;
    src_w_q = 9'd256;
    src_h_q = 9'd256;
    dst_w_q = 13'd256;
    dst_h_q = 13'd256;
    nearest_q = 1'b0;
    fail_count_o = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic longint clamp_size(input longint v, input longint hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Output pixel center mapped back to the source, FRAC fractional bits
  function automatic longint src_coord(input longint o, input longint ssize,
                                       input longint dsize);
    longint num;
    num = ((2 * o + 1) * ssize) << FRAC;
    return num / (2 * dsize) - HALF;
  endfunction

  // Edge-clamped read of the shadow frame store
  function automatic longint pixel_at(input longint x, input longint y, input longint c,
                                      input longint sw, input longint sh);
    longint cx;
    longint cy;
    cx = (x < 0) ? 0 : ((x > sw - 1) ? sw - 1 : x);
    cy = (y < 0) ? 0 : ((y > sh - 1) ? sh - 1 : y);
    return longint'(pix_mem[(cy * IMG_W + cx) * CHANS + c]);
  endfunction

  function automatic longint nearest_idx(input longint s);
    if (s >= 0) return (s + HALF) >>> FRAC;
    return (s <= -HALF) ? -1 : 0;
  endfunction

  function automatic logic [7:0] resized_pixel(input longint col, input longint row,
                                               input longint ch);
    longint sw, sh, dw, dh, sx, sy, ix, iy, fx, fy, gx, gy, acc;
    sw = clamp_size(longint'(src_w_q), IMG_W);
    sh = clamp_size(longint'(src_h_q), IMG_H);
    dw = clamp_size(longint'(dst_w_q), DST_LIMIT);
    dh = clamp_size(longint'(dst_h_q), DST_LIMIT);
    if (ch > CHANS - 1) ch = CHANS - 1;
    sx = src_coord(col, sw, dw);
    sy = src_coord(row, sh, dh);
    if (nearest_q) return 8'(pixel_at(nearest_idx(sx), nearest_idx(sy), ch, sw, sh));
    ix = sx >>> FRAC;
    iy = sy >>> FRAC;
    fx = sx & (ONE - 1);
    fy = sy & (ONE - 1);
    gx = ONE - fx;
    gy = ONE - fy;
    acc = pixel_at(ix, iy, ch, sw, sh) * gx * gy
        + pixel_at(ix + 1, iy, ch, sw, sh) * fx * gy
        + pixel_at(ix, iy + 1, ch, sw, sh) * gx * fy
        + pixel_at(ix + 1, iy + 1, ch, sw, sh) * fx * fy
        + (64'sd1 << (2 * FRAC - 1));
    acc = acc >>> (2 * FRAC);
    return (acc > 255) ? 8'd255 : 8'(acc);
  endfunction

  // Watch all three channels at the clock edge
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni) begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_SRC_WIDTH:  src_w_q = cfg_mon.data[8:0];
          CFG_SRC_HEIGHT: src_h_q = cfg_mon.data[8:0];
          CFG_DST_WIDTH:  dst_w_q = cfg_mon.data;
          CFG_DST_HEIGHT: dst_h_q = cfg_mon.data;
          CFG_INTERP:     nearest_q = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == REQ_LOAD) begin
          if (in_mon.col < IMG_W && in_mon.row < IMG_H)
            pix_mem[(int'(in_mon.row) * IMG_W + int'(in_mon.col)) * CHANS
                    + int'(in_mon.channel)] = in_mon.pixel_in;
        end else begin
          expected_pixels.push_back(resized_pixel(longint'(in_mon.col),
                                                  longint'(in_mon.row),
                                                  longint'(in_mon.channel)));
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("pixel %0d with no query outstanding",
                                    out_mon.pixel_out));
        end else begin
          want = expected_pixels.pop_front();
          if (out_mon.pixel_out !== want)
            report_mismatch($sformatf("pixel_out %0d, predicted %0d",
                                      out_mon.pixel_out, want));
        end
      end
      pending_o = expected_pixels.size();
    end
  end

endmodule

>>> tb/sv/bilinear_image_resize_core_test.sv
`timescale 1ns / 1ps
// Stimulus, handshake pacing and verdict for the bilinear image resize core.
module bilinear_image_resize_core_test;
  import bir_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 150;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_pct;
  int   stall_pct;
  int   hold_requests;
  int   holds_served;
  int   hold_left;
  int   quiet_cycles;

  bir_in_if  in_ch ();
  bir_out_if out_ch ();
  bir_cfg_if cfg_ch ();

  bilinear_image_resize_core dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  bir_resize_checker checker_u (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int unsigned sat_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'd0;
    if (r < 30) return 8'd255;
    return 8'($urandom);
  endfunction

  task automatic send_item(input logic req, input int unsigned col, input int unsigned row,
                           input int unsigned ch, input logic [7:0] pix);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.col      <= 12'(col);
    in_ch.row      <= 12'(row);
    in_ch.channel  <= 2'(ch);
    in_ch.pixel_in <= pix;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= 13'(val);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every predicted pixel, then let a trailing operation finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int unsigned sw, input int unsigned sh, input int unsigned dw,
                           input int unsigned dh, input int unsigned mode);
    write_reg(CFG_SRC_WIDTH, sw | ($urandom_range(15) << 9));
    write_reg(CFG_SRC_HEIGHT, sh | ($urandom_range(15) << 9));
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
    write_reg(CFG_INTERP, mode);
    if ($urandom_range(1)) write_reg(3'(5 + $urandom_range(2)), $urandom);
  endtask

  // One setting: fill the used part of the image, then mostly queries
  task automatic run_phase(input int unsigned sw_reg, input int unsigned sh_reg,
                           input int unsigned dw_reg, input int unsigned dh_reg,
                           input int unsigned mode, input int unsigned c_lo,
                           input int unsigned c_hi, input int n_items,
                           input int pace, input bit long_hold);
    int unsigned sw, sh, dw, dh, r;
    drain();
    idle_pct  = (pace == 1) ? 53 : ((pace == 3) ? 20 : 0);
    stall_pct = (pace == 2) ? 53 : ((pace == 3) ? 20 : 0);
    configure(sw_reg, sh_reg, dw_reg, dh_reg, mode);
    sw = sat_size(sw_reg & 511, 256);
    sh = sat_size(sh_reg & 511, 256);
    dw = sat_size(dw_reg & 8191, DST_LIMIT);
    dh = sat_size(dh_reg & 8191, DST_LIMIT);
    for (int unsigned y = 0; y < sh; y++)
      for (int unsigned x = 0; x < sw; x++)
        for (int unsigned c = c_lo; c <= c_hi; c++)
          send_item(REQ_LOAD, x, y, c, pick_pixel());
    if (long_hold) hold_requests++;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      if (r < 8)
        send_item(REQ_LOAD, $urandom_range(sw - 1), $urandom_range(sh - 1),
                  $urandom_range(c_hi, c_lo), pick_pixel());
      else if (r < 12)
        send_item(REQ_LOAD, 256 + $urandom_range(3839), $urandom_range(4095),
                  $urandom_range(3), pick_pixel());
      else if (r < 22)
        send_item(REQ_QUERY, $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(c_hi, c_lo), pick_pixel());
      else
        send_item(REQ_QUERY, $urandom_range(dw - 1), $urandom_range(dh - 1),
                  $urandom_range(c_hi, c_lo), pick_pixel());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_requests = 0;
    holds_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.col = '0;
    in_ch.row = '0;
    in_ch.channel = '0;
    in_ch.pixel_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SRC_WIDTH;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 2x2 checkerboard, upscaled, edges and far-out queries
    configure(2, 2, 3, 5, 0);
    for (int unsigned y = 0; y < 2; y++)
      for (int unsigned x = 0; x < 2; x++)
        for (int unsigned c = 0; c < 4; c++)
          send_item(REQ_LOAD, x, y, c, ((x ^ y) & 1) ? 8'd255 : 8'd0);
    send_item(REQ_LOAD, 4095, 4095, 3, 8'd255);
    send_item(REQ_LOAD, 256, 0, 0, 8'd255);
    send_item(REQ_QUERY, 0, 0, 0, 8'd0);
    send_item(REQ_QUERY, 2, 4, 1, 8'd255);
    send_item(REQ_QUERY, 1, 2, 2, 8'd0);
    send_item(REQ_QUERY, 4095, 4095, 3, 8'd0);
    send_item(REQ_QUERY, 4095, 0, 0, 8'd0);
    drain();
    write_reg(CFG_INTERP, 1);
    send_item(REQ_QUERY, 0, 0, 0, 8'd0);
    send_item(REQ_QUERY, 1, 3, 2, 8'd0);
    send_item(REQ_QUERY, 4095, 4095, 3, 8'd0);

    // Random settings, including saturated and extreme register values
    run_phase(4, 3, 7, 5, 0, 0, 3, 90, 0, 0);
    run_phase(3, 3, 2, 2, 1, 0, 3, 70, 1, 0);
    run_phase(300, 0, 4096, 1, 0, 2, 2, 60, 2, 1);
    run_phase(1, 256, 0, 8191, 1, 3, 3, 60, 3, 0);
    run_phase(1, 1, 1, 1, 0, 0, 3, 30, 0, 0);
    run_phase(5, 4, 13, 9, 1, 0, 3, 80, 1, 0);
    run_phase(6, 2, 4095, 3, 0, 0, 1, 80, 2, 1);
    run_phase(7, 5, 3, 11, 0, 0, 3, 80, 3, 0);
    drain();

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
